/* hw/rtl/htnm_pkg.sv */
// Shared types, constants and command/status structs of the height to normal map block.
package htnm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;
  localparam int UNIT_Q12   = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = $clog2(3 * MAX_WIDTH);

  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 13;
  localparam int GAIN_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  localparam int MAG_W   = 24;  // |height difference| times gain
  localparam int L2_W    = 50;  // squared Q12 length
  localparam int Q_W     = 57;  // quotient of 2^56 by the squared length
  localparam int RS_W    = 29;  // reciprocal length, Q16
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = RS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 16;  // signed Q12 components of the summed vector

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_HEIGHT_SCALE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] height;
  } req_t;

  typedef struct packed {
    logic signed [7:0] normal_x;
    logic signed [7:0] normal_y;
    logic              last_of_frame;
  } rsp_t;

  typedef enum logic [2:0] {
    RD_NONE = 3'd0,
    RD_C    = 3'd1,
    RD_R    = 3'd2,
    RD_L    = 3'd3,
    RD_U    = 3'd4
  } rd_sel_t;

  typedef enum logic [4:0] {
    MOP_NONE  = 5'd0,
    MOP_AX    = 5'd1,
    MOP_AY    = 5'd2,
    MOP_BX    = 5'd3,
    MOP_BY    = 5'd4,
    MOP_SQ_AX = 5'd5,
    MOP_SQ_AY = 5'd6,
    MOP_SQ_BX = 5'd7,
    MOP_SQ_BY = 5'd8,
    MOP_N_AX  = 5'd9,
    MOP_N_AY  = 5'd10,
    MOP_N_AZ  = 5'd11,
    MOP_N_BX  = 5'd12,
    MOP_N_BY  = 5'd13,
    MOP_N_BZ  = 5'd14,
    MOP_SQ_SX = 5'd15,
    MOP_SQ_SY = 5'd16,
    MOP_SQ_SZ = 5'd17,
    MOP_O_X   = 5'd18,
    MOP_O_Y   = 5'd19
  } mop_t;

  typedef enum logic [1:0] {
    RS_NONE = 2'd0,
    RS_A    = 2'd1,
    RS_B    = 2'd2,
    RS_S    = 2'd3
  } rs_dst_t;

  typedef struct packed {
    logic    take;
    logic    wr;
    rd_sel_t rd;
    mop_t    mop;
    logic    rs_start;
    rs_dst_t rs_ld;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic store;
    logic emit;
    logic rs_done;
    logic rsp_free;
  } sts_t;

endpackage

/* hw/rtl/htnm_rsqrt.sv */
// Iterative reciprocal square root: restoring divide of 2^56, then a digit-by-digit square root.
module htnm_rsqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [htnm_pkg::L2_W-1:0] l2,
  output logic                     done,
  output logic [htnm_pkg::RS_W-1:0] root
);
  import htnm_pkg::*;

  localparam int CNT_W  = $clog2(Q_W);
  localparam int SREM_W = RS_W + 2;

  logic                div_busy;
  logic                sqrt_busy;
  logic [CNT_W-1:0]    cnt;
  logic [L2_W-1:0]     d;
  logic [L2_W-1:0]     rem;
  logic [2*RS_W-1:0]   q;
  logic [SREM_W-1:0]   srem;

  logic                nb;
  logic [L2_W:0]       t;
  logic                ge;
  logic [L2_W-1:0]     rem_next;
  logic [SREM_W+1:0]   t2;
  logic [SREM_W+1:0]   trial;
  logic                sge;

  // One quotient bit per cycle; the dividend is a single one at bit 56.
  assign nb       = (cnt == CNT_W'(Q_W - 1));
  assign t        = {rem, nb};
  assign ge       = (t >= {1'b0, d});
  assign rem_next = ge ? L2_W'(t - {1'b0, d}) : L2_W'(t);

  // One root bit per cycle, two radicand bits consumed from the top of q.
  assign t2    = {srem, q[2*RS_W-1 -: 2]};
  assign trial = (SREM_W+2)'({root, 2'b01});
  assign sge   = (t2 >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      sqrt_busy <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        div_busy <= 1'b1;
        cnt      <= CNT_W'(Q_W - 1);
        d        <= (l2 == '0) ? L2_W'(1) : l2;
        rem      <= '0;
        q        <= '0;
      end else if (div_busy) begin
        rem <= rem_next;
        q   <= {q[2*RS_W-2:0], ge};
        if (cnt == '0) begin
          div_busy  <= 1'b0;
          sqrt_busy <= 1'b1;
          cnt       <= CNT_W'(RS_W - 1);
          srem      <= '0;
          root      <= '0;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end else if (sqrt_busy) begin
        srem <= sge ? SREM_W'(t2 - trial) : SREM_W'(t2);
        root <= {root[RS_W-2:0], sge};
        q    <= {q[2*RS_W-3:0], 2'b00};
        if (cnt == '0) begin
          sqrt_busy <= 1'b0;
          done      <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !(div_busy || sqrt_busy))
    else $error("reciprocal unit restarted while busy");

endmodule

/* hw/rtl/htnm_datapath.sv */
// Datapath: configuration, counters, three-row store, shared multiplier and output register.
module htnm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  htnm_pkg::req_t                    req,
  input  logic                              cfg_we,
  input  logic [htnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htnm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  htnm_pkg::cmd_t                    cmd,
  output htnm_pkg::sts_t                    sts,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output htnm_pkg::rsp_t                    rsp
);
  import htnm_pkg::*;

  logic [CFG_WIDTH_W-1:0]  cfg_w;
  logic [CFG_HEIGHT_W-1:0] cfg_h;
  logic [GAIN_W-1:0]       gain;
  logic [WID_W-1:0]        eff_w;
  logic [ROW_W-1:0]        eff_h;

  logic [COL_W-1:0] in_col, out_col;
  logic [ROW_W-1:0] in_row, out_row;
  logic [1:0]       in_slot, out_slot;

  op_t        op_q;
  logic [7:0] hgt_q;

  logic [7:0]        mem [3*MAX_WIDTH];
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        rdata;
  rd_sel_t           rd_q;
  logic [7:0]        h0, hr, hl, hu;
  logic [7:0]        hr_e, hl_e, hu_e, hd_e;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  p;
  mop_t               mop_q;
  logic [PROD_W-1:0]  rnd16, rnd21;
  logic [SUM_W-1:0]   term;

  logic [MAG_W-1:0]   vax, vay, vbx, vby;
  logic               vax_n, vay_n, vbx_n, vby_n;
  logic [L2_W-1:0]    acc;
  logic [RS_W-1:0]    ra, rb, rs;
  logic signed [SUM_W-1:0] sx, sy, sz;
  logic [SUM_W-1:0]   sx_m, sy_m, sz_m;
  logic [7:0]         ox, oy;

  logic            rs_done;
  logic [RS_W-1:0] rs_root;

  logic in_wrap, out_wrap, last;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] sat8(input logic neg, input logic [PROD_W-1:0] mag);
    logic [7:0] r;
    if (neg) begin
      r = (mag > PROD_W'(128)) ? 8'h80 : 8'(-mag[7:0]);
    end else begin
      r = (mag > PROD_W'(127)) ? 8'h7f : mag[7:0];
    end
    sat8 = r;
  endfunction

  // Size registers are clamped into their legal ranges.
  assign eff_w = (cfg_w == '0) ? WID_W'(1) :
                 (int'(cfg_w) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_w);
  assign eff_h = (cfg_h == '0) ? ROW_W'(1) :
                 (int'(cfg_h) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(cfg_h);

  assign in_wrap  = (WID_W'(in_col) + WID_W'(1) >= eff_w);
  assign out_wrap = (WID_W'(out_col) + WID_W'(1) >= eff_w);
  assign last     = out_wrap && ({1'b0, out_row} + (ROW_W+1)'(1) >= {1'b0, eff_h});

  assign sts.store    = (op_q == OP_SAMPLE) && (in_row < eff_h);
  assign sts.emit     = sts.store ? (in_row != '0)
                                  : ((op_q == OP_DRAIN) && (in_row >= eff_h) && (out_row < eff_h));
  assign sts.rs_done  = rs_done;
  assign sts.rsp_free = !rsp_valid || rsp_ready;

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= CFG_WIDTH_W'(256);
      cfg_h    <= CFG_HEIGHT_W'(256);
      gain     <= GAIN_W'(4096);
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          cfg_w <= cfg_data[CFG_WIDTH_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_h <= cfg_data[CFG_HEIGHT_W-1:0];
        end
        CFG_HEIGHT_SCALE: begin
          gain <= cfg_data[GAIN_W-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT) begin
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
      end
    end else begin
      if (cmd.wr) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + ROW_W'(1);
          in_slot <= (in_slot == 2'd2) ? 2'd0 : in_slot + 2'd1;
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (cmd.out_ld) begin
        if (last) begin
          in_col   <= '0;
          in_row   <= '0;
          in_slot  <= '0;
          out_col  <= '0;
          out_row  <= '0;
          out_slot <= '0;
        end else if (out_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= (out_slot == 2'd2) ? 2'd0 : out_slot + 2'd1;
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= req.op;
      hgt_q <= req.height;
    end
  end

  // Row store: one write and one registered read per cycle.
  assign waddr = ADDR_W'(in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);

  always_comb begin
    case (cmd.rd)
      RD_R:    raddr = ADDR_W'(out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col + COL_W'(1));
      RD_L:    raddr = ADDR_W'(out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col - COL_W'(1));
      RD_U:    raddr = ADDR_W'((out_slot == 2'd0) ? 2'd2 : out_slot - 2'd1) * ADDR_W'(MAX_WIDTH)
                       + ADDR_W'(out_col);
      default: raddr = ADDR_W'(out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= hgt_q;
    end
    if (cmd.rd != RD_NONE) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q  <= RD_NONE;
      mop_q <= MOP_NONE;
    end else begin
      rd_q  <= cmd.rd;
      mop_q <= cmd.mop;
    end
  end

  always_ff @(posedge clk) begin
    case (rd_q)
      RD_C:    h0 <= rdata;
      RD_R:    hr <= rdata;
      RD_L:    hl <= rdata;
      RD_U:    hu <= rdata;
      default: begin
      end
    endcase
  end

  // Neighbors outside the image take the center sample.
  assign hr_e = out_wrap ? h0 : hr;
  assign hl_e = (out_col != '0) ? hl : h0;
  assign hu_e = (out_row != '0) ? hu : h0;
  assign hd_e = ({1'b0, out_row} + (ROW_W+1)'(1) < {1'b0, eff_h}) ? hgt_q : h0;

  assign sx_m = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign sy_m = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  assign sz_m = sz[SUM_W-1] ? SUM_W'(-sz) : SUM_W'(sz);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop)
      MOP_AX:    begin mul_a = MUL_A_W'(absdiff(hd_e, h0)); mul_b = MUL_B_W'(gain); end
      MOP_AY:    begin mul_a = MUL_A_W'(absdiff(hr_e, h0)); mul_b = MUL_B_W'(gain); end
      MOP_BX:    begin mul_a = MUL_A_W'(absdiff(hu_e, h0)); mul_b = MUL_B_W'(gain); end
      MOP_BY:    begin mul_a = MUL_A_W'(absdiff(hl_e, h0)); mul_b = MUL_B_W'(gain); end
      MOP_SQ_AX: begin mul_a = MUL_A_W'(vax); mul_b = MUL_B_W'(vax); end
      MOP_SQ_AY: begin mul_a = MUL_A_W'(vay); mul_b = MUL_B_W'(vay); end
      MOP_SQ_BX: begin mul_a = MUL_A_W'(vbx); mul_b = MUL_B_W'(vbx); end
      MOP_SQ_BY: begin mul_a = MUL_A_W'(vby); mul_b = MUL_B_W'(vby); end
      MOP_N_AX:  begin mul_a = MUL_A_W'(vax); mul_b = ra; end
      MOP_N_AY:  begin mul_a = MUL_A_W'(vay); mul_b = ra; end
      MOP_N_AZ:  begin mul_a = MUL_A_W'(UNIT_Q12); mul_b = ra; end
      MOP_N_BX:  begin mul_a = MUL_A_W'(vbx); mul_b = rb; end
      MOP_N_BY:  begin mul_a = MUL_A_W'(vby); mul_b = rb; end
      MOP_N_BZ:  begin mul_a = MUL_A_W'(UNIT_Q12); mul_b = rb; end
      MOP_SQ_SX: begin mul_a = MUL_A_W'(sx_m); mul_b = MUL_B_W'(sx_m); end
      MOP_SQ_SY: begin mul_a = MUL_A_W'(sy_m); mul_b = MUL_B_W'(sy_m); end
      MOP_SQ_SZ: begin mul_a = MUL_A_W'(sz_m); mul_b = MUL_B_W'(sz_m); end
      MOP_O_X:   begin mul_a = MUL_A_W'(sx_m); mul_b = rs; end
      MOP_O_Y:   begin mul_a = MUL_A_W'(sy_m); mul_b = rs; end
      default:   begin end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Rounding half away from zero is done on magnitudes; sign is applied after.
  assign rnd16 = (p + (PROD_W'(1) << 15)) >> 16;
  assign rnd21 = (p + (PROD_W'(1) << 20)) >> 21;
  assign term  = rnd16[SUM_W-1:0];

  // Write-back of the product issued in the previous cycle.
  always_ff @(posedge clk) begin
    case (mop_q)
      MOP_AX:    begin vax <= p[MAG_W-1:0]; vax_n <= (hd_e > h0); end
      MOP_AY:    begin vay <= p[MAG_W-1:0]; vay_n <= (hr_e > h0); end
      MOP_BX:    begin vbx <= p[MAG_W-1:0]; vbx_n <= (hu_e < h0); end
      MOP_BY:    begin vby <= p[MAG_W-1:0]; vby_n <= (hl_e < h0); end
      MOP_SQ_AX,
      MOP_SQ_BX: acc <= L2_W'(p) + L2_W'(UNIT_Q12 * UNIT_Q12);
      MOP_SQ_SX: acc <= L2_W'(p);
      MOP_SQ_AY,
      MOP_SQ_BY,
      MOP_SQ_SY,
      MOP_SQ_SZ: acc <= acc + L2_W'(p);
      MOP_N_AX:  sx <= vax_n ? -$signed(term) : $signed(term);
      MOP_N_AY:  sy <= vay_n ? -$signed(term) : $signed(term);
      MOP_N_AZ:  sz <= $signed(term);
      MOP_N_BX:  sx <= sx + (vbx_n ? -$signed(term) : $signed(term));
      MOP_N_BY:  sy <= sy + (vby_n ? -$signed(term) : $signed(term));
      MOP_N_BZ:  sz <= sz + $signed(term);
      MOP_O_X:   ox <= sat8(sx[SUM_W-1], rnd21);
      MOP_O_Y:   oy <= sat8(sy[SUM_W-1], rnd21);
      default:   begin end
    endcase
  end

  htnm_rsqrt u_rsqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.rs_start),
    .l2    (acc),
    .done  (rs_done),
    .root  (rs_root)
  );

  always_ff @(posedge clk) begin
    case (cmd.rs_ld)
      RS_A:    ra <= rs_root;
      RS_B:    rb <= rs_root;
      RS_S:    rs <= rs_root;
      default: begin end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      rsp.normal_x      <= ox;
      rsp.normal_y      <= oy;
      rsp.last_of_frame <= last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!rsp_valid || rsp_ready))
    else $error("output register loaded while a result is still pending");

  a_store_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (sts.store && rd_q == RD_NONE))
    else $error("row store written for an item that may not be stored");

  a_acc_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.rs_start |-> (mop_q == MOP_NONE && cmd.mop == MOP_NONE))
    else $error("reciprocal unit started before the squared length settled");

endmodule

/* hw/rtl/htnm_ctrl.sv */
// Controller: one-hot sequencer that steps the datapath through one item.
module htnm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  htnm_pkg::sts_t sts,
  output htnm_pkg::cmd_t cmd
);
  import htnm_pkg::*;

  localparam int NS = 37;

  typedef enum logic [NS-1:0] {
    S_IDLE    = NS'(1) << 0,
    S_DECIDE  = NS'(1) << 1,
    S_RD_C    = NS'(1) << 2,
    S_RD_R    = NS'(1) << 3,
    S_RD_L    = NS'(1) << 4,
    S_RD_U    = NS'(1) << 5,
    S_RD_W    = NS'(1) << 6,
    S_AX      = NS'(1) << 7,
    S_AY      = NS'(1) << 8,
    S_BX      = NS'(1) << 9,
    S_BY      = NS'(1) << 10,
    S_SQ_AX   = NS'(1) << 11,
    S_SQ_AY   = NS'(1) << 12,
    S_A_SET   = NS'(1) << 13,
    S_A_GO    = NS'(1) << 14,
    S_A_WAIT  = NS'(1) << 15,
    S_SQ_BX   = NS'(1) << 16,
    S_SQ_BY   = NS'(1) << 17,
    S_B_SET   = NS'(1) << 18,
    S_B_GO    = NS'(1) << 19,
    S_B_WAIT  = NS'(1) << 20,
    S_N_AX    = NS'(1) << 21,
    S_N_AY    = NS'(1) << 22,
    S_N_AZ    = NS'(1) << 23,
    S_N_BX    = NS'(1) << 24,
    S_N_BY    = NS'(1) << 25,
    S_N_BZ    = NS'(1) << 26,
    S_SQ_SX   = NS'(1) << 27,
    S_SQ_SY   = NS'(1) << 28,
    S_SQ_SZ   = NS'(1) << 29,
    S_S_SET   = NS'(1) << 30,
    S_S_GO    = NS'(1) << 31,
    S_S_WAIT  = NS'(1) << 32,
    S_O_X     = NS'(1) << 33,
    S_O_Y     = NS'(1) << 34,
    S_O_W     = NS'(1) << 35,
    S_FIN     = NS'(1) << 36
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.take     = 1'b0;
    cmd.wr       = 1'b0;
    cmd.rd       = RD_NONE;
    cmd.mop      = MOP_NONE;
    cmd.rs_start = 1'b0;
    cmd.rs_ld    = RS_NONE;
    cmd.out_ld   = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.take = req_valid;
        if (req_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.wr     = sts.store;
        state_next = sts.emit ? S_RD_C : S_IDLE;
      end
      S_RD_C:  begin cmd.rd = RD_C; state_next = S_RD_R; end
      S_RD_R:  begin cmd.rd = RD_R; state_next = S_RD_L; end
      S_RD_L:  begin cmd.rd = RD_L; state_next = S_RD_U; end
      S_RD_U:  begin cmd.rd = RD_U; state_next = S_RD_W; end
      S_RD_W:  state_next = S_AX;
      S_AX:    begin cmd.mop = MOP_AX;    state_next = S_AY; end
      S_AY:    begin cmd.mop = MOP_AY;    state_next = S_BX; end
      S_BX:    begin cmd.mop = MOP_BX;    state_next = S_BY; end
      S_BY:    begin cmd.mop = MOP_BY;    state_next = S_SQ_AX; end
      S_SQ_AX: begin cmd.mop = MOP_SQ_AX; state_next = S_SQ_AY; end
      S_SQ_AY: begin cmd.mop = MOP_SQ_AY; state_next = S_A_SET; end
      S_A_SET: state_next = S_A_GO;
      S_A_GO:  begin cmd.rs_start = 1'b1; state_next = S_A_WAIT; end
      S_A_WAIT: begin
        if (sts.rs_done) begin
          cmd.rs_ld  = RS_A;
          state_next = S_SQ_BX;
        end
      end
      S_SQ_BX: begin cmd.mop = MOP_SQ_BX; state_next = S_SQ_BY; end
      S_SQ_BY: begin cmd.mop = MOP_SQ_BY; state_next = S_B_SET; end
      S_B_SET: state_next = S_B_GO;
      S_B_GO:  begin cmd.rs_start = 1'b1; state_next = S_B_WAIT; end
      S_B_WAIT: begin
        if (sts.rs_done) begin
          cmd.rs_ld  = RS_B;
          state_next = S_N_AX;
        end
      end
      S_N_AX:  begin cmd.mop = MOP_N_AX;  state_next = S_N_AY; end
      S_N_AY:  begin cmd.mop = MOP_N_AY;  state_next = S_N_AZ; end
      S_N_AZ:  begin cmd.mop = MOP_N_AZ;  state_next = S_N_BX; end
      S_N_BX:  begin cmd.mop = MOP_N_BX;  state_next = S_N_BY; end
      S_N_BY:  begin cmd.mop = MOP_N_BY;  state_next = S_N_BZ; end
      S_N_BZ:  begin cmd.mop = MOP_N_BZ;  state_next = S_SQ_SX; end
      S_SQ_SX: begin cmd.mop = MOP_SQ_SX; state_next = S_SQ_SY; end
      S_SQ_SY: begin cmd.mop = MOP_SQ_SY; state_next = S_SQ_SZ; end
      S_SQ_SZ: begin cmd.mop = MOP_SQ_SZ; state_next = S_S_SET; end
      S_S_SET: state_next = S_S_GO;
      S_S_GO:  begin cmd.rs_start = 1'b1; state_next = S_S_WAIT; end
      S_S_WAIT: begin
        if (sts.rs_done) begin
          cmd.rs_ld  = RS_S;
          state_next = S_O_X;
        end
      end
      S_O_X:   begin cmd.mop = MOP_O_X; state_next = S_O_Y; end
      S_O_Y:   begin cmd.mop = MOP_O_Y; state_next = S_O_W; end
      S_O_W:   state_next = S_FIN;
      S_FIN: begin
        if (sts.rsp_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/height_to_normal_map.sv */
// Top level of the height to normal map block: controller, datapath and ports.
//
// Height samples enter one item at a time in raster order; each one is stored in a
// three-row store, and once the row below a pixel is arriving the block computes that
// pixel's normal from its four clamped neighbors, so results lag the input by one row.
// Drain items issued after the last sample of a frame emit the final row, one result
// each; drains sent too early and samples sent after the frame's last sample are
// absorbed without a result. For an item that yields a result, the three reciprocal
// lengths per pixel are computed one after another on a single iterative unit (a 57-step
// restoring divide followed by a 29-step square root, one bit per cycle), which takes
// most of the time; the rest goes to the four row store reads, one per cycle, and
// nineteen products on one shared multiplier. The output register lets the next item be
// accepted while a finished result still waits. Writing image_width or image_height
// restarts the frame; height_scale applies from the next pixel. Configuration must be
// written only while the block is idle. The row store needs no clearing after reset.
module height_to_normal_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  htnm_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output htnm_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [htnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htnm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import htnm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; every stored value lives in the datapath.
  htnm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  htnm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* tb/height_to_normal_map_tb.sv */
// Self-checking testbench of the height to normal map block.
module height_to_normal_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htnm_pkg::*;

  // Extra settling time so that any straggling pixel can finish.
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS  = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  height_to_normal_map dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Items waiting to be offered, and normals that the block still owes us.
  req_t pending_items[$];
  rsp_t expected_normals[$];
  int   error_count = 0;
  int   items_queued = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   req_taken = 1'b0;

  // Our own copy of the block's state: three rows of heights plus the counters.
  byte unsigned heights[3*MAX_WIDTH];
  int unsigned  in_col, in_row, out_col, out_row;
  int unsigned  img_w, img_h, gain;

  function automatic int unsigned used_width();
    return (img_w < 1) ? 1 : ((img_w > MAX_WIDTH) ? MAX_WIDTH : img_w);
  endfunction

  function automatic int unsigned used_height();
    return (img_h < 1) ? 1 : ((img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h);
  endfunction

  // Bitwise integer square root, floor of sqrt(v).
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Reciprocal of a Q12 vector length, as Q16, truncated.
  function automatic longint unsigned recip_length(longint a, longint b, longint c);
    longint unsigned ua, ub, uc, l2;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    uc = (c < 0) ? -c : c;
    l2 = ua * ua + ub * ub + uc * uc;
    if (l2 == 0) l2 = 1;
    return int_sqrt((64'd1 << 56) / l2);
  endfunction

  // Scales by the reciprocal length and rounds half away from zero.
  function automatic longint round_scale(longint a, longint unsigned rs, int sh);
    longint unsigned mag, p;
    mag = (a < 0) ? -a : a;
    p = (mag * rs + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [7:0] clamp8(longint v);
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[7:0];
  endfunction

  function automatic longint height_at(int unsigned r, int unsigned c);
    return longint'(heights[(r % 3) * MAX_WIDTH + (c % MAX_WIDTH)]);
  endfunction

  // Works out the normal of the next pixel due and advances the output counters.
  task automatic predict_normal();
    int unsigned w, h, c, r;
    longint g, h0, hr, hl, hu, hd, ax, ay, bx, by, sx, sy, sz;
    longint unsigned ra, rb, rs;
    rsp_t n;
    w = used_width();
    h = used_height();
    c = out_col;
    r = out_row;
    g = longint'(gain);
    h0 = height_at(r, c);
    hr = (c + 1 < w) ? height_at(r, c + 1) : h0;
    hl = (c > 0) ? height_at(r, c - 1) : h0;
    hu = (r > 0) ? height_at(r - 1, c) : h0;
    hd = (r + 1 < h) ? height_at(r + 1, c) : h0;
    ax = -(hd - h0) * g;
    ay = -(hr - h0) * g;
    bx = (hu - h0) * g;
    by = (hl - h0) * g;
    ra = recip_length(ax, ay, UNIT_Q12);
    rb = recip_length(bx, by, UNIT_Q12);
    sx = round_scale(ax, ra, 16) + round_scale(bx, rb, 16);
    sy = round_scale(ay, ra, 16) + round_scale(by, rb, 16);
    sz = round_scale(UNIT_Q12, ra, 16) + round_scale(UNIT_Q12, rb, 16);
    rs = recip_length(sx, sy, sz);
    n.normal_x = clamp8(round_scale(sx, rs, 21));
    n.normal_y = clamp8(round_scale(sy, rs, 21));
    n.last_of_frame = (c + 1 >= w) && (r + 1 >= h);
    expected_normals.push_back(n);
    if (n.last_of_frame) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Applies one accepted item to the state copy.
  task automatic predict_item(req_t it);
    int unsigned w, h;
    bit emitted;
    w = used_width();
    h = used_height();
    emitted = 1'b0;
    if (it.op == OP_SAMPLE) begin
      // A sample past the frame's last one is swallowed.
      if (in_row >= h) return;
      heights[(in_row % 3) * MAX_WIDTH + (in_col % MAX_WIDTH)] = it.height;
      if (in_row > 0) begin
        predict_normal();
        emitted = 1'b1;
      end
      // The frame-ending pixel already cleared the counters; do not step them then.
      if (!emitted || in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0) begin
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
    end else if (in_row >= h && out_row < h) begin
      // Drains only count once every sample of the frame is in.
      predict_normal();
    end
  endtask

  // Input side: offer the next item at the falling edge, with random gaps; also drive rsp_ready at random.
  always @(negedge clk) begin : driver
    logic nv;
    req_t np;
    nv = req_valid;
    np = req;
    if (req_valid && req_taken) nv = 1'b0;
    if (!nv && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      np = pending_items.pop_front();
      nv = 1'b1;
    end
    req_valid <= nv;
    req <= np;
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Rising edge: note accepted items, predict them, check delivered results.
  always @(posedge clk) begin : monitor
    rsp_t want;
    req_taken = 1'b0;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d last=%0b", $time,
                   rsp.normal_x, rsp.normal_y, rsp.last_of_frame);
          error_count++;
        end else begin
          want = expected_normals.pop_front();
          if (rsp.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time,
                     want.normal_x, rsp.normal_x);
            error_count++;
          end
          if (rsp.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time,
                     want.normal_y, rsp.normal_y);
            error_count++;
          end
          if (rsp.last_of_frame !== want.last_of_frame) begin
            $display("%0t: last_of_frame expected %0b actual %0b", $time,
                     want.last_of_frame, rsp.last_of_frame);
            error_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        req_taken = 1'b1;
        predict_item(req);
      end
    end
  end

  task automatic queue_item(op_t op, int unsigned hgt);
    req_t it;
    it.op = op;
    it.height = hgt[7:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Waits until every item is in and every normal is out, then lets stragglers finish.
  task automatic settle();
    while (pending_items.size() > 0 || req_valid || expected_normals.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_IMAGE_WIDTH: begin
        img_w = value & 'h1FF;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        img_h = value & 'h1FFF;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      default: gain = value & 'hFFFF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h, int unsigned g);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_HEIGHT_SCALE, g);
  endtask

  // Picks a height: half the time a gentle slope, otherwise an extreme or pure noise.
  function automatic int unsigned pick_height(int unsigned prev);
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 255 : 0;
      1: return $urandom_range(255);
      default: return (prev + $urandom_range(16) - 8) & 'hFF;
    endcase
  endfunction

  // A whole frame of samples, then drains for its last row; noisy adds stray drains and a late sample.
  task automatic queue_frame(int unsigned w, int unsigned h, bit noisy);
    int unsigned prev;
    prev = $urandom_range(255);
    for (int unsigned i = 0; i < w * h; i++) begin
      prev = pick_height(prev);
      if (noisy && $urandom_range(19) == 0) queue_item(OP_DRAIN, $urandom_range(255));
      queue_item(OP_SAMPLE, prev);
    end
    if (noisy) queue_item(OP_SAMPLE, $urandom_range(255));
    for (int unsigned i = 0; i < w; i++) queue_item(OP_DRAIN, $urandom_range(255));
  endtask

  initial begin : stimulus
    int unsigned w, h;
    for (int i = 0; i < 3 * MAX_WIDTH; i++) heights[i] = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    img_w = 256; img_h = 256; gain = 4096;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: early drain, extreme heights at full gain, a late sample, frame end,
    // and an early drain of the next frame.
    set_size(4, 3, 65535);
    queue_item(OP_DRAIN, 8'hFF);
    for (int i = 0; i < 12; i++) queue_item(OP_SAMPLE, (i % 3 == 0) ? 255 : ((i & 1) ? 0 : 128));
    queue_item(OP_SAMPLE, 8'h55);
    for (int i = 0; i < 4; i++) queue_item(OP_DRAIN, 8'hAA);
    queue_item(OP_DRAIN, 8'h00);
    settle();

    // Single pixel frame with zero gain, then width and height registers at zero.
    set_size(1, 1, 0);
    queue_item(OP_SAMPLE, 255);
    queue_item(OP_DRAIN, 0);
    settle();
    set_size(0, 0, 1);
    queue_item(OP_SAMPLE, 7);
    queue_item(OP_DRAIN, 0);
    settle();

    // Oversized registers clamp to the maximum; only the start of the first row is fed here.
    set_size(511, 8191, 12345);
    for (int i = 0; i < 6; i++) queue_item(OP_SAMPLE, (i & 1) ? 255 : 0);
    settle();

    // Random frames: the receiver idles more first, then the sender, then neither idles.
    while (items_queued < RANDOM_ITEMS + 40) begin
      if (items_queued < 340) begin
        send_idle_pct = 32; recv_idle_pct = 50;
      end else if (items_queued < 640) begin
        send_idle_pct = 50; recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // A full-width frame only while it still fits in the item budget.
      if ($urandom_range(29) == 0 && items_queued + 3 * MAX_WIDTH < RANDOM_ITEMS) begin
        w = 256;
        h = 2;
      end else begin
        w = $urandom_range(16, 1);
        h = $urandom_range(8, 1);
      end
      case ($urandom_range(3))
        0: set_size(w, h, $urandom_range(65535));
        1: set_size(w, h, $urandom_range(1) ? 65535 : 0);
        default: set_size(w, h, $urandom_range(8192));
      endcase
      queue_frame(w, h, $urandom_range(3) == 0);
      settle();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    if (error_count == 0) begin
      $display("** height_to_normal_map: PASSED **");
    end else begin
      $display("** height_to_normal_map: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(40_000_000);
    $display("** height_to_normal_map: FAILED **");
    $finish;
  end

endmodule

/* height_to_normal_map.f */
hw/rtl/htnm_pkg.sv
hw/rtl/htnm_rsqrt.sv
hw/rtl/htnm_datapath.sv
hw/rtl/htnm_ctrl.sv
hw/rtl/height_to_normal_map.sv
tb/height_to_normal_map_tb.sv
